// ----- sv/assert_macros.svh -----
// Assertion helpers used by the generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- sv/xoshiro_pkg.sv -----
package xoshiro_pkg;

  localparam int FUNC_W = 2;
  localparam int WORD_W = 64;
  localparam int SUM_W  = 11;

  // Splitmix64 constants
  localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;

  // Double construction
  localparam logic [SUM_W-1:0] EXP_CAP = 11'd1022;
  localparam int MANT_W = 52;

  typedef enum logic [FUNC_W-1:0] {
    FN_RESEED = 2'd0,
    FN_INT    = 2'd1,
    FN_DBL    = 2'd2,
    FN_UNUSED = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_ADD,
    ST_SEED_MULA,
    ST_SEED_MULB,
    ST_DRAW_A,
    ST_DRAW_B,
    ST_LZ_BYTE,
    ST_LZ_SUM,
    ST_MANT_CHK,
    ST_EMIT
  } state_t;

  // What a finished draw is used for
  typedef enum logic [1:0] {
    PH_INT,
    PH_LZ,
    PH_MANT,
    PH_BUMP
  } phase_t;

endpackage

// ----- sv/xoshiro256ss_uniform_generator_top.sv -----
// xoshiro256** generator with splitmix64 seeding and uniform double output.
// Input channel (in_valid/in_ready): in_func selects reseed (0), 64-bit integer
// draw (1), uniform double draw (2); code 3 is taken and ignored. in_seed is
// used by reseed only. Result channel (out_valid/out_ready) carries out_value.
// One item is worked on at a time; in_ready is high only while idle.
// A generator step runs as ST_DRAW_A (state update plus w1*5), then ST_DRAW_B
// (rotate and *9). Integer draw: one step, then ST_EMIT. Double draw: each
// exponent draw is a step and a leading-zero count (ST_LZ_BYTE, ST_LZ_SUM),
// repeated while the draw is all zero; then a step for the mantissa, checked
// in ST_MANT_CHK, and one more step when the mantissa is zero. Reseed: per
// state word ST_SEED_ADD, then two products on the single 32x32 multiplier,
// each from three partial products. Reseed gives no result.
// After reset the block seeds itself with seed zero (not ready meanwhile).
// A finished result sits in the output register; while the receiver stalls
// the next input can be taken, and a new result waits in its final state
// until the output register is free.
`include "assert_macros.svh"

module xoshiro256ss_uniform_generator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [xoshiro_pkg::FUNC_W-1:0]   in_func,
  input  logic [xoshiro_pkg::WORD_W-1:0]   in_seed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [xoshiro_pkg::WORD_W-1:0]   out_value
);
  import xoshiro_pkg::*;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [WORD_W-1:0]  words_r [4];
  logic [WORD_W-1:0]  words_nxt [4];
  logic [WORD_W-1:0]  sacc_r, sacc_nxt;
  logic [WORD_W-1:0]  mul_x_r, mul_x_nxt;
  logic [WORD_W-1:0]  prod_r, prod_nxt;
  logic [1:0]         mstep_r, mstep_nxt;
  logic [1:0]         widx_r, widx_nxt;
  logic [WORD_W-1:0]  t5_r, t5_nxt;
  logic [WORD_W-1:0]  d_r, d_nxt;
  logic [7:0]         bnz_r, bnz_nxt;
  logic [2:0]         blz_r [8];
  logic [2:0]         blz_nxt [8];
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   exp_r, exp_nxt;
  logic [WORD_W-1:0]  res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_value_r, out_value_nxt;

  logic               in_xfer;
  logic               out_free;
  logic [WORD_W-1:0]  mul_b;
  logic [31:0]        mop_a, mop_b;
  logic [WORD_W-1:0]  mprod;
  logic [WORD_W-1:0]  prod_fin;
  logic [WORD_W-1:0]  rot7;
  logic [WORD_W-1:0]  res9;
  logic [6:0]         lz_k;
  logic [SUM_W-1:0]   sum_add;
  logic [SUM_W-1:0]   sum_cap;
  logic [SUM_W-1:0]   exp_new;
  logic               lz_more;

  function automatic logic [2:0] byte_lz(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        n = 3'(7 - i);
      end
    end
    return n;
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // Shared 32x32 multiplier: low 64 bits of a 64x64 product over three steps
  assign mul_b = (state_r == ST_SEED_MULA) ? MIX_MUL_A : MIX_MUL_B;
  always_comb begin
    case (mstep_r)
      2'd0: begin
        mop_a = mul_x_r[31:0];
        mop_b = mul_b[31:0];
      end
      2'd1: begin
        mop_a = mul_x_r[31:0];
        mop_b = mul_b[63:32];
      end
      default: begin
        mop_a = mul_x_r[63:32];
        mop_b = mul_b[31:0];
      end
    endcase
  end
  assign mprod    = WORD_W'(mop_a) * WORD_W'(mop_b);
  assign prod_fin = (mstep_r == 2'd0) ? mprod :
                    {prod_r[63:32] + mprod[31:0], prod_r[31:0]};

  // Output scrambler second half: rotl(w1*5, 7) * 9
  assign rot7 = {t5_r[56:0], t5_r[63:57]};
  assign res9 = rot7 + {rot7[60:0], 3'b000};

  // Leading-zero count from the per-byte flags, highest nonzero byte wins
  always_comb begin
    lz_k = 7'd64;
    for (int j = 0; j < 8; j++) begin
      if (bnz_r[j]) begin
        lz_k = 7'((7 - j) * 8) + {4'b0000, blz_r[j]};
      end
    end
  end
  assign sum_add = sum_r + {4'b0000, lz_k};
  assign lz_more = (lz_k == 7'd64) && (sum_add < EXP_CAP);
  assign sum_cap = (sum_add > EXP_CAP) ? EXP_CAP : sum_add;
  assign exp_new = EXP_CAP - sum_cap;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (func_t'(in_func))
            FN_RESEED: state_nxt = ST_SEED_ADD;
            FN_INT:    state_nxt = ST_DRAW_A;
            FN_DBL:    state_nxt = ST_DRAW_A;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEED_ADD: state_nxt = ST_SEED_MULA;
      ST_SEED_MULA: begin
        if (mstep_r == 2'd2) begin
          state_nxt = ST_SEED_MULB;
        end
      end
      ST_SEED_MULB: begin
        if (mstep_r == 2'd2) begin
          state_nxt = (widx_r == 2'd3) ? ST_IDLE : ST_SEED_ADD;
        end
      end
      ST_DRAW_A: state_nxt = ST_DRAW_B;
      ST_DRAW_B: begin
        case (phase_r)
          PH_LZ:   state_nxt = ST_LZ_BYTE;
          PH_MANT: state_nxt = ST_MANT_CHK;
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_LZ_BYTE: state_nxt = ST_LZ_SUM;
      ST_LZ_SUM: begin
        if (lz_more || exp_new != '0) begin
          state_nxt = ST_DRAW_A;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_MANT_CHK: begin
        state_nxt = (d_r[MANT_W-1:0] != '0) ? ST_EMIT : ST_DRAW_A;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    phase_nxt     = phase_r;
    words_nxt     = words_r;
    sacc_nxt      = sacc_r;
    mul_x_nxt     = mul_x_r;
    prod_nxt      = prod_r;
    mstep_nxt     = mstep_r;
    widx_nxt      = widx_r;
    t5_nxt        = t5_r;
    d_nxt         = d_r;
    bnz_nxt       = bnz_r;
    blz_nxt       = blz_r;
    sum_nxt       = sum_r;
    exp_nxt       = exp_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;

    // drop the held result once the receiver takes it
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          sacc_nxt  = in_seed;
          widx_nxt  = 2'd0;
          sum_nxt   = '0;
          phase_nxt = (func_t'(in_func) == FN_INT) ? PH_INT : PH_LZ;
        end
      end
      ST_SEED_ADD: begin
        sacc_nxt  = sacc_r + GOLDEN_INC;
        mul_x_nxt = sacc_nxt ^ (sacc_nxt >> 30);
        mstep_nxt = 2'd0;
      end
      ST_SEED_MULA: begin
        prod_nxt  = prod_fin;
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd2) begin
          mul_x_nxt = prod_fin ^ (prod_fin >> 27);
          mstep_nxt = 2'd0;
        end
      end
      ST_SEED_MULB: begin
        prod_nxt  = prod_fin;
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd2) begin
          words_nxt[widx_r] = prod_fin ^ (prod_fin >> 31);
          widx_nxt          = widx_r + 2'd1;
          mstep_nxt         = 2'd0;
        end
      end
      ST_DRAW_A: begin
        // advance the xoshiro256 state, start the scrambler
        t5_nxt       = words_r[1] + {words_r[1][61:0], 2'b00};
        words_nxt[2] = words_r[2] ^ words_r[0] ^ {words_r[1][46:0], 17'd0};
        words_nxt[1] = words_r[1] ^ words_r[2] ^ words_r[0];
        words_nxt[0] = words_r[0] ^ words_r[3] ^ words_r[1];
        words_nxt[3] = words_r[3] ^ words_r[1];
        words_nxt[3] = {words_nxt[3][18:0], words_nxt[3][63:19]};
      end
      ST_DRAW_B: begin
        d_nxt = res9;
        case (phase_r)
          PH_INT:  res_nxt = res9;
          PH_BUMP: res_nxt = {1'b0, exp_r + {10'd0, res9[63]}, {MANT_W{1'b0}}};
          default: res_nxt = res_r;
        endcase
      end
      ST_LZ_BYTE: begin
        for (int j = 0; j < 8; j++) begin
          bnz_nxt[j] = (d_r[8*j +: 8] != 8'd0);
          blz_nxt[j] = byte_lz(d_r[8*j +: 8]);
        end
      end
      ST_LZ_SUM: begin
        sum_nxt = sum_add;
        if (!lz_more) begin
          exp_nxt   = exp_new;
          phase_nxt = PH_MANT;
          res_nxt   = '0;
        end
      end
      ST_MANT_CHK: begin
        res_nxt   = {1'b0, exp_r, d_r[MANT_W-1:0]};
        phase_nxt = PH_BUMP;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SEED_ADD;
      sacc_r      <= '0;
      widx_r      <= 2'd0;
      mstep_r     <= 2'd0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_INT;
      sum_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      sacc_r      <= sacc_nxt;
      widx_r      <= widx_nxt;
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r     <= words_nxt;
    mul_x_r     <= mul_x_nxt;
    prod_r      <= prod_nxt;
    t5_r        <= t5_nxt;
    d_r         <= d_nxt;
    bnz_r       <= bnz_nxt;
    blz_r       <= blz_nxt;
    exp_r       <= exp_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  // Checks
  `ASSERT_IMP(a_lz_below_cap, clk, rst_n, state_r == ST_LZ_SUM, sum_r < EXP_CAP)
  `ASSERT_IMP(a_exp_range, clk, rst_n, state_r == ST_MANT_CHK,
              (exp_r != '0) && (exp_r <= EXP_CAP))
  `ASSERT_NXT(a_busy_after_take, clk, rst_n,
              in_xfer && (func_t'(in_func) != FN_UNUSED), !in_ready)
  `ASSERT_IMP(a_mstep_range, clk, rst_n,
              (state_r == ST_SEED_MULA) || (state_r == ST_SEED_MULB), mstep_r != 2'd3)

endmodule
